// ===== hdl/mpbm_pkg.sv =====
// shared types and constants of the multi-pattern byte matcher
`timescale 1ns / 1ps
package mpbm_pkg;

    localparam logic OP_SCAN  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    localparam logic [10:0] NO_WORD = 11'h7FF;

    localparam int CMD_DEPTH = 2;
    localparam int RES_DEPTH = 4;

    typedef struct packed {
        logic [11:0] base;
        logic [12:0] parent;
        logic [11:0] fail;
        logic [10:0] word;
    } entry_t;

    typedef struct packed {
        logic        opcode;
        logic        write_ok;
        logic [7:0]  text_byte;
        logic        start_of_text;
        logic [11:0] index;
        entry_t      entry;
    } cmd_t;

    typedef struct packed {
        logic [9:0]  word_id;
        logic [31:0] end_position;
        logic        last_match;
    } result_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_GOT_NODE,
        S_GOT_CHILD,
        S_MISS,
        S_WALK,
        S_FLUSH
    } eng_state_t;

endpackage

// ===== hdl/mpbm_front.sv =====
// front end: accepts input words, classifies them and queues commands
`timescale 1ns / 1ps
module mpbm_front
    import mpbm_pkg::*;
#(
    parameter int NODE_COUNT = 4096
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic        opcode,
    input  logic [7:0]  text_byte,
    input  logic        start_of_text,
    input  logic [11:0] entry_index,
    input  logic [11:0] entry_base,
    input  logic [12:0] entry_parent,
    input  logic [11:0] entry_fail,
    input  logic [10:0] entry_word,
    output logic        cmd_valid,
    output cmd_t        cmd,
    input  logic        cmd_ready
);

    localparam int PW = $clog2(CMD_DEPTH);

    cmd_t          q_reg [CMD_DEPTH];
    logic [PW-1:0] wp_reg, wp_next;
    logic [PW-1:0] rp_reg, rp_next;
    logic [PW:0]   cnt_reg, cnt_next;
    cmd_t          in_cmd;
    logic          do_push;
    logic          do_pop;

    always_comb
    begin
        in_cmd.opcode        = opcode;
        in_cmd.write_ok      = (opcode == OP_WRITE) && (32'(entry_index) < NODE_COUNT);
        in_cmd.text_byte     = text_byte;
        in_cmd.start_of_text = start_of_text;
        in_cmd.index         = entry_index;
        in_cmd.entry.base    = entry_base;
        in_cmd.entry.parent  = entry_parent;
        in_cmd.entry.fail    = entry_fail;
        in_cmd.entry.word    = entry_word;
    end

    assign full      = (cnt_reg == (PW+1)'(CMD_DEPTH));
    assign cmd_valid = (cnt_reg != '0);
    assign cmd       = q_reg[rp_reg];
    assign do_push   = push && !full;
    assign do_pop    = cmd_valid && cmd_ready;

    always_comb
    begin
        wp_next  = do_push ? wp_reg + 1'b1 : wp_reg;
        rp_next  = do_pop ? rp_reg + 1'b1 : rp_reg;
        cnt_next = cnt_reg + (PW+1)'(do_push) - (PW+1)'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wp_reg] <= in_cmd;
        end
    end

endmodule

// ===== hdl/mpbm_res_fifo.sv =====
// result queue between the matching engine and the result ports
`timescale 1ns / 1ps
module mpbm_res_fifo
    import mpbm_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    wr,
    input  result_t wdata,
    output logic    wfull,
    output logic    empty,
    input  logic    pop,
    output result_t rdata
);

    localparam int PW = $clog2(RES_DEPTH);

    result_t       q_reg [RES_DEPTH];
    logic [PW-1:0] wp_reg, wp_next;
    logic [PW-1:0] rp_reg, rp_next;
    logic [PW:0]   cnt_reg, cnt_next;
    logic          do_wr;
    logic          do_rd;

    assign wfull = (cnt_reg == (PW+1)'(RES_DEPTH));
    assign empty = (cnt_reg == '0);
    assign rdata = q_reg[rp_reg];
    assign do_wr = wr && !wfull;
    assign do_rd = pop && !empty;

    always_comb
    begin
        wp_next  = do_wr ? wp_reg + 1'b1 : wp_reg;
        rp_next  = do_rd ? rp_reg + 1'b1 : rp_reg;
        cnt_next = cnt_reg + (PW+1)'(do_wr) - (PW+1)'(do_rd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            q_reg[wp_reg] <= wdata;
        end
    end

endmodule

// ===== hdl/mpbm_engine.sv =====
// back end: node table, trie walk and output chain walk
`timescale 1ns / 1ps
module mpbm_engine
    import mpbm_pkg::*;
#(
    parameter int NODE_COUNT         = 4096,
    parameter int WORD_COUNT         = 1024,
    parameter int MAX_PATTERN_LENGTH = 64
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    cmd_valid,
    input  cmd_t    cmd,
    output logic    cmd_ready,
    output logic    res_push,
    output result_t res,
    input  logic    res_full
);

    localparam int AW = $clog2(NODE_COUNT);
    localparam int SW = $clog2(MAX_PATTERN_LENGTH + 1);

    entry_t     mem [NODE_COUNT];
    entry_t     rdata_reg;
    logic [AW-1:0] rd_addr;
    logic       mem_we;

    eng_state_t state_reg, state_next;
    logic [AW-1:0] node_reg, node_next;
    logic [AW-1:0] cur_reg, cur_next;
    logic [AW-1:0] w_reg, w_next;
    logic [12:0]   idx_reg, idx_next;
    logic [7:0]    byte_reg, byte_next;
    logic [31:0]   pos_reg, pos_next;
    logic [SW-1:0] steps_reg, steps_next;
    entry_t        nent_reg, nent_next;
    logic          pend_valid_reg, pend_valid_next;
    logic [9:0]    pend_reg, pend_next;

    logic [12:0]   idx_sum;
    logic          idx_ok;
    logic          child_hit;
    logic [AW-1:0] miss_link;
    logic [AW-1:0] walk_link;
    logic          steps_left;
    logic          walk_go;
    logic          walk_emit;
    logic          walk_stall;
    logic [31:0]   start_pos;
    logic [AW-1:0] start_node;
    logic          is_write;

    assign is_write   = (cmd.opcode == OP_WRITE);
    assign idx_sum    = {1'b0, rdata_reg.base} + 13'(byte_reg);
    assign idx_ok     = 32'(idx_sum) < NODE_COUNT;
    assign child_hit  = !rdata_reg.parent[12]
                        && (32'(rdata_reg.parent[11:0]) == 32'(node_reg));
    assign miss_link  = (32'(nent_reg.fail) < NODE_COUNT) ? AW'(nent_reg.fail) : '0;
    assign walk_link  = (32'(rdata_reg.fail) < NODE_COUNT) ? AW'(rdata_reg.fail) : '0;
    assign steps_left = 32'(steps_reg) < MAX_PATTERN_LENGTH;
    assign walk_go    = steps_left && (w_reg != '0);
    assign walk_emit  = walk_go && !rdata_reg.word[10]
                        && (32'(rdata_reg.word[9:0]) < WORD_COUNT);
    assign walk_stall = walk_emit && pend_valid_reg && res_full;
    assign start_pos  = cmd.start_of_text ? 32'd0 : pos_reg;
    assign start_node = cmd.start_of_text ? '0 : cur_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid && !is_write)
                begin
                    state_next = S_GOT_NODE;
                end
            end
            S_GOT_NODE:
            begin
                state_next = idx_ok ? S_GOT_CHILD : S_MISS;
            end
            S_GOT_CHILD:
            begin
                if (!child_hit)
                begin
                    state_next = S_MISS;
                end
                else if (rdata_reg.word == NO_WORD)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_WALK;
                end
            end
            S_MISS:
            begin
                state_next = (node_reg == '0) ? S_IDLE : S_GOT_NODE;
            end
            S_WALK:
            begin
                if (!walk_stall && !walk_go)
                begin
                    state_next = S_FLUSH;
                end
            end
            S_FLUSH:
            begin
                if (!(pend_valid_reg && res_full))
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        cmd_ready       = 1'b0;
        mem_we          = 1'b0;
        rd_addr         = node_reg;
        res_push        = 1'b0;
        res.word_id     = pend_reg;
        res.end_position = pos_reg;
        res.last_match  = 1'b0;
        node_next       = node_reg;
        cur_next        = cur_reg;
        w_next          = w_reg;
        idx_next        = idx_reg;
        byte_next       = byte_reg;
        pos_next        = pos_reg;
        steps_next      = steps_reg;
        nent_next       = nent_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    if (is_write)
                    begin
                        mem_we = cmd.write_ok;
                    end
                    else
                    begin
                        pos_next   = (start_pos == 32'hFFFF_FFFF) ? start_pos
                                                                  : start_pos + 32'd1;
                        cur_next   = start_node;
                        node_next  = start_node;
                        rd_addr    = start_node;
                        byte_next  = cmd.text_byte;
                        steps_next = '0;
                    end
                end
            end
            S_GOT_NODE:
            begin
                nent_next = rdata_reg;
                idx_next  = idx_sum;
                if (idx_ok)
                begin
                    rd_addr = AW'(idx_sum);
                end
            end
            S_GOT_CHILD:
            begin
                if (child_hit)
                begin
                    node_next  = AW'(idx_reg);
                    cur_next   = AW'(idx_reg);
                    w_next     = AW'(idx_reg);
                    rd_addr    = AW'(idx_reg);
                    steps_next = '0;
                end
            end
            S_MISS:
            begin
                if (node_reg == '0)
                begin
                    cur_next = '0;
                end
                else if (!steps_left)
                begin
                    node_next = '0;
                    rd_addr   = '0;
                end
                else
                begin
                    node_next  = miss_link;
                    rd_addr    = miss_link;
                    steps_next = steps_reg + 1'b1;
                end
            end
            S_WALK:
            begin
                rd_addr = w_reg;
                if (!walk_stall && walk_go)
                begin
                    if (walk_emit)
                    begin
                        res_push        = pend_valid_reg;
                        pend_next       = rdata_reg.word[9:0];
                        pend_valid_next = 1'b1;
                    end
                    w_next     = walk_link;
                    rd_addr    = walk_link;
                    steps_next = steps_reg + 1'b1;
                end
            end
            S_FLUSH:
            begin
                res.last_match = 1'b1;
                if (pend_valid_reg && !res_full)
                begin
                    res_push        = 1'b1;
                    pend_valid_next = 1'b0;
                end
            end
            default:
            begin
                rd_addr = node_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cur_reg        <= '0;
            pos_reg        <= '0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cur_reg        <= cur_next;
            pos_reg        <= pos_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        node_reg  <= node_next;
        w_reg     <= w_next;
        idx_reg   <= idx_next;
        byte_reg  <= byte_next;
        steps_reg <= steps_next;
        nent_reg  <= nent_next;
        pend_reg  <= pend_next;
    end

    // node table, one read and at most one write per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[AW'(cmd.index)] <= cmd.entry;
        end
        rdata_reg <= mem[rd_addr];
    end

endmodule

// ===== hdl/multi_pattern_byte_matcher.sv =====
// top level of the multi-pattern byte matcher
`timescale 1ns / 1ps
// Aho-Corasick matcher over a double-array trie in a node table with one
// read port and one write port. A table write is made as its command is
// taken in the idle state. Each trie step takes two table reads, the node
// and then the candidate child. Each failure link taken adds a read of the
// failure node before the two reads repeat. The output chain is then walked
// along the failure links, node by node, holding while the result queue is
// full, and a flush state closes it. The single table read port bounds each
// step. Input words queue in a two-entry command buffer and results in a
// four-entry result queue, so either side may stall on its own.
module multi_pattern_byte_matcher
    import mpbm_pkg::*;
#(
    parameter int NODE_COUNT         = 4096,
    parameter int WORD_COUNT         = 1024,
    parameter int MAX_PATTERN_LENGTH = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic        opcode,
    input  logic [7:0]  text_byte,
    input  logic        start_of_text,
    input  logic [11:0] entry_index,
    input  logic [11:0] entry_base,
    input  logic signed [12:0] entry_parent,
    input  logic [11:0] entry_fail,
    input  logic signed [10:0] entry_word,
    output logic        empty,
    input  logic        pop,
    output logic [9:0]  word_id,
    output logic [31:0] end_position,
    output logic        last_match
);

    logic    cmd_valid;
    cmd_t    cmd;
    logic    cmd_ready;
    logic    res_push;
    result_t res;
    logic    res_full;
    result_t res_out;

    mpbm_front #(
        .NODE_COUNT (NODE_COUNT)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .opcode        (opcode),
        .text_byte     (text_byte),
        .start_of_text (start_of_text),
        .entry_index   (entry_index),
        .entry_base    (entry_base),
        .entry_parent  (entry_parent),
        .entry_fail    (entry_fail),
        .entry_word    (entry_word),
        .cmd_valid     (cmd_valid),
        .cmd           (cmd),
        .cmd_ready     (cmd_ready)
    );

    mpbm_engine #(
        .NODE_COUNT         (NODE_COUNT),
        .WORD_COUNT         (WORD_COUNT),
        .MAX_PATTERN_LENGTH (MAX_PATTERN_LENGTH)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_ready (cmd_ready),
        .res_push  (res_push),
        .res       (res),
        .res_full  (res_full)
    );

    mpbm_res_fifo u_res_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (res_push),
        .wdata (res),
        .wfull (res_full),
        .empty (empty),
        .pop   (pop),
        .rdata (res_out)
    );

    assign word_id      = res_out.word_id;
    assign end_position = res_out.end_position;
    assign last_match   = res_out.last_match;

endmodule

// ===== hdl/mpbm_checker.sv =====
// port-level checker for the multi-pattern byte matcher and its bind
`timescale 1ns / 1ps
module mpbm_checker
#(
    parameter int WORD_COUNT = 1024
)
(
    input logic        clk,
    input logic        rst_n,
    input logic        empty,
    input logic        pop,
    input logic [9:0]  word_id,
    input logic [31:0] end_position,
    input logic        last_match
);

    a_res_held: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty)
        else $error("result word dropped while stalled");

    a_res_stable: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> $stable(word_id) && $stable(end_position)
                           && $stable(last_match))
        else $error("stalled result word changed");

    a_word_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> 32'(word_id) < WORD_COUNT)
        else $error("word id out of range");

    a_pos_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> end_position != 32'd0)
        else $error("end position is zero");

endmodule

bind multi_pattern_byte_matcher mpbm_checker #(
    .WORD_COUNT (WORD_COUNT)
) u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .empty        (empty),
    .pop          (pop),
    .word_id      (word_id),
    .end_position (end_position),
    .last_match   (last_match)
);
